>>> design/ffid_pkg.sv
// Package for the free-fall / impact detector: constants, types and
// the controller-to-datapath command and status structs. No dependencies.
package ffid_pkg;

   localparam int WarmupSamples = 20;
   localparam int FreefallMin   = 2;
   localparam int HoldLength    = 20;

   // ceil(2^23 / 5): warmup sum over 5 by multiply and shift, exact below 2^20
   localparam logic [20:0] WarmupRecip = 21'd1677722;

   // configuration register indexes
   localparam logic [2:0] RegCountShift = 3'd0;
   localparam logic [2:0] RegLowGRatio  = 3'd1;
   localparam logic [2:0] RegImpRatio   = 3'd2;
   localparam logic [2:0] RegImpMargin  = 3'd3;
   localparam logic [2:0] RegBaseFloor  = 3'd4;
   localparam logic [2:0] RegBaseAlpha  = 3'd5;
   localparam logic [2:0] RegImpWindow  = 3'd6;
   localparam logic [2:0] RegCooldown   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_MUL,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;     // capture sample, square axes
      logic sum;      // add squares, start root
      logic sqrt_step;
      logic mul;      // threshold products
      logic decide;   // update detector state
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
   } status_type;

endpackage

>>> design/ffid_ctrl.sv
// Controller state machine for the detector: sequences the datapath
// and runs the request/response handshake. Depends on ffid_pkg.
module ffid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ffid_pkg::status_type  status,
   output ffid_pkg::cmd_type     cmd
);

   ffid_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ffid_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ffid_pkg::ST_SQUARE;
            end
         end
         ffid_pkg::ST_SQUARE: begin
            cmd.sum  = 1'b1;
            state_in = ffid_pkg::ST_SQRT;
         end
         ffid_pkg::ST_SQRT: begin
            if (status.sqrt_done) begin
               state_in = ffid_pkg::ST_MUL;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         ffid_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ffid_pkg::ST_DECIDE;
         end
         ffid_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ffid_pkg::ST_OUT;
         end
         ffid_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ffid_pkg::ST_IDLE;
            end
         end
         default: state_in = ffid_pkg::ST_IDLE;
      endcase
   end

endmodule

>>> design/ffid_datapath.sv
// Datapath for the detector: sample scaling, squares, bit-serial square
// root, threshold products and detector state. Depends on ffid_pkg.
module ffid_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ffid_pkg::cmd_type     cmd,
   output ffid_pkg::status_type  status,
   input  logic [39:0]           req_tdata,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output logic [39:0]           rsp_tdata
);

   // configuration
   logic [1:0]  count_shift_ff;
   logic [7:0]  low_g_ratio_ff;
   logic [9:0]  impact_ratio_ff;
   logic [11:0] impact_margin_ff;
   logic [11:0] baseline_floor_ff;
   logic [15:0] baseline_alpha_ff;
   logic [7:0]  impact_window_ff;
   logic [7:0]  cooldown_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_shift_ff     <= 2'd1;
         low_g_ratio_ff     <= 8'd115;
         impact_ratio_ff    <= 10'd461;
         impact_margin_ff   <= 12'd614;
         baseline_floor_ff  <= 12'd82;
         baseline_alpha_ff  <= 16'd1966;
         impact_window_ff   <= 8'd20;
         cooldown_length_ff <= 8'd60;
      end else if (csr_we) begin
         unique case (csr_index)
            ffid_pkg::RegCountShift: count_shift_ff     <= csr_wdata[1:0];
            ffid_pkg::RegLowGRatio:  low_g_ratio_ff     <= csr_wdata[7:0];
            ffid_pkg::RegImpRatio:   impact_ratio_ff    <= csr_wdata[9:0];
            ffid_pkg::RegImpMargin:  impact_margin_ff   <= csr_wdata[11:0];
            ffid_pkg::RegBaseFloor:  baseline_floor_ff  <= csr_wdata[11:0];
            ffid_pkg::RegBaseAlpha:  baseline_alpha_ff  <= csr_wdata[15:0];
            ffid_pkg::RegImpWindow:  impact_window_ff   <= csr_wdata[7:0];
            ffid_pkg::RegCooldown:   cooldown_length_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // absolute axis values, scaled to Q10 g
   function automatic logic [14:0] axis_abs(input logic [11:0] v, input logic [1:0] sh);
      logic [11:0] a;
      a = v[11] ? 12'(-v) : v;
      return 15'(a) << sh;
   endfunction

   logic [14:0] ax_in, ay_in, az_in;
   logic        nonzero_ff;
   logic [29:0] sx_ff, sy_ff, sz_ff;
   logic [31:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] bit_ff;
   logic [14:0] mag_ff;

   assign ax_in = axis_abs(req_tdata[11:0],  count_shift_ff);
   assign ay_in = axis_abs(req_tdata[23:12], count_shift_ff);
   assign az_in = axis_abs(req_tdata[35:24], count_shift_ff);

   // capture the sample as squares, one per axis
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff      <= 30'(ax_in) * 30'(ax_in);
         sy_ff      <= 30'(ay_in) * 30'(ay_in);
         sz_ff      <= 30'(az_in) * 30'(az_in);
         nonzero_ff <= |req_tdata[35:0];
      end
   end

   // bit-serial square root, two radicand bits per step
   logic [31:0] trial;
   assign trial = root_ff + bit_ff;
   assign status.sqrt_done = (bit_ff == 32'd0);

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         rem_ff  <= 32'(sx_ff) + 32'(sy_ff) + 32'(sz_ff);
         root_ff <= '0;
         bit_ff  <= 32'h4000_0000;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end
   assign mag_ff = root_ff[14:0];

   // detector state
   logic [19:0] warmup_sum_ff;
   logic [4:0]  warmup_count_ff;
   logic [23:0] baseline_ff;
   logic [7:0]  low_count_ff, window_count_ff, cooldown_count_ff;
   logic [4:0]  hold_count_ff;
   logic        held_ff, event_ff;

   // threshold products, registered
   logic [33:0] b_low_ff;
   logic [33:0] b_imp_ff;
   logic [39:0] b_keep_ff;
   logic [39:0] m_alpha_ff;
   logic [16:0] alpha_inv_w;
   assign alpha_inv_w = 17'h10000 - 17'(baseline_alpha_ff);

   // warmup sum after this sample; its quotient by 5 is registered with the products
   logic [19:0] wsum_next;
   logic [40:0] wq_prod;
   logic [17:0] wq_ff;
   assign wsum_next = warmup_sum_ff + 20'(mag_ff);
   assign wq_prod   = 41'(wsum_next) * 41'(ffid_pkg::WarmupRecip);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         b_low_ff   <= 34'(baseline_ff) * 34'(low_g_ratio_ff);
         b_imp_ff   <= 34'(baseline_ff) * 34'(impact_ratio_ff);
         b_keep_ff  <= 40'(baseline_ff) * 40'(alpha_inv_w);
         m_alpha_ff <= 40'({mag_ff, 8'd0}) * 40'(baseline_alpha_ff);
         wq_ff      <= wq_prod[40:23];
      end
   end

   // sum * 256 / 20 = 64 * (sum / 5) + floor(64 * remainder / 5)
   logic [2:0]  wrem;
   logic [5:0]  wfrac;
   logic [23:0] wavg;
   assign wrem = wsum_next[2:0] - ({wq_ff[0], 2'b00} + wq_ff[2:0]);

   always_comb begin
      unique case (wrem)
         3'd0:    wfrac = 6'd0;
         3'd1:    wfrac = 6'd12;
         3'd2:    wfrac = 6'd25;
         3'd3:    wfrac = 6'd38;
         3'd4:    wfrac = 6'd51;
         default: wfrac = 6'd0;
      endcase
   end
   assign wavg = {wq_ff, 6'd0} + 24'(wfrac);

   // compares
   logic [30:0] mq16;
   logic [22:0] mq8;
   logic [27:0] m2560, b7, b13;
   logic [24:0] b_marg;
   logic [39:0] ema;
   logic [23:0] floor_q;
   logic        is_low, is_imp;
   assign mq16   = {mag_ff, 16'd0};
   assign mq8    = {mag_ff, 8'd0};
   assign m2560  = 28'(mag_ff) * 28'd2560;
   assign b7     = 28'(baseline_ff) * 28'd7;
   assign b13    = 28'(baseline_ff) * 28'd13;
   assign b_marg = 25'(baseline_ff) + 25'({impact_margin_ff, 8'd0});
   assign is_low = 34'(mq16) < b_low_ff;
   assign is_imp = (34'(mq16) >= b_imp_ff) && (25'(mq8) >= b_marg);
   assign ema    = b_keep_ff + m_alpha_ff + 40'd32768;
   assign floor_q = {baseline_floor_ff, 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_sum_ff     <= '0;
         warmup_count_ff   <= '0;
         baseline_ff       <= '0;
         low_count_ff      <= '0;
         window_count_ff   <= '0;
         cooldown_count_ff <= '0;
         hold_count_ff     <= '0;
         held_ff           <= 1'b0;
         event_ff          <= 1'b0;
      end else if (cmd.load) begin
         event_ff <= 1'b0;
      end else if (cmd.decide && nonzero_ff) begin
         event_ff <= 1'b0;
         if (hold_count_ff != 5'd0) begin
            hold_count_ff <= hold_count_ff - 5'd1;
         end else begin
            held_ff <= 1'b0;
         end
         if (warmup_count_ff < 5'(ffid_pkg::WarmupSamples)) begin
            warmup_sum_ff   <= wsum_next;
            warmup_count_ff <= warmup_count_ff + 5'd1;
            if (warmup_count_ff + 5'd1 >= 5'(ffid_pkg::WarmupSamples)) begin
               baseline_ff <= (wavg < floor_q) ? floor_q : wavg;
            end
         end else if (cooldown_count_ff != 8'd0) begin
            cooldown_count_ff <= cooldown_count_ff - 8'd1;
         end else if (is_low) begin
            if (low_count_ff != 8'hff) begin
               low_count_ff <= low_count_ff + 8'd1;
            end
            if (low_count_ff + 9'd1 >= 9'(ffid_pkg::FreefallMin)
                || low_count_ff >= 8'(ffid_pkg::FreefallMin)) begin
               window_count_ff <= impact_window_ff;
            end
         end else if (window_count_ff != 8'd0) begin
            window_count_ff <= window_count_ff - 8'd1;
            if (is_imp) begin
               low_count_ff      <= '0;
               window_count_ff   <= '0;
               cooldown_count_ff <= cooldown_length_ff;
               event_ff          <= 1'b1;
               held_ff           <= 1'b1;
               hold_count_ff     <= 5'(ffid_pkg::HoldLength);
            end
         end else begin
            low_count_ff <= '0;
            if (m2560 > b7 && m2560 < b13) begin
               baseline_ff <= ema[39:16];
            end
         end
      end
   end

   // fields from bit 0: fall_event, fall_held, baseline_ready, magnitude,
   // gravity_level
   assign rsp_tdata = {7'd0, baseline_ff[22:8],
                       nonzero_ff ? mag_ff : 15'd0,
                       warmup_count_ff >= 5'(ffid_pkg::WarmupSamples),
                       held_ff, event_ff};

endmodule

>>> design/fall_freefall_impact_detector.sv
// Top level of the free-fall / impact detector: joins controller and
// datapath. Depends on ffid_pkg, ffid_ctrl and ffid_datapath.

// One sample is in flight at a time and yields one response. The accepting
// edge captures and squares the axes; then the controller sums the squares,
// runs the bit-serial square root and sees it finish, forms the threshold
// products and the warmup quotient, and updates the state, after which the
// response is valid. The next sample is taken in the cycle after the response
// is taken at the earliest. All-zero samples leave state alone.
module fall_freefall_impact_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // accel_x[11:0], accel_y[11:0], accel_z[11:0], pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // fall_event, fall_held, baseline_ready,
                                   // magnitude[14:0], gravity_level[14:0], pad
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ffid_pkg::cmd_type    cmd;
   ffid_pkg::status_type status;

   ffid_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   ffid_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_tdata, .csr_we, .csr_index,
      .csr_wdata, .rsp_tdata
   );

   // a fall is never flagged without the held indication
   a_event_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("fall event without held flag");

   // no new sample taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("sample accepted while response pending");

   // a fall only once the baseline is ready
   a_event_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2])
      else $error("fall event before baseline ready");

endmodule

>>> verif/tb.sv
// Self-checking testbench for fall_freefall_impact_detector: drives accelerometer
// samples over the request stream, checks every response against an in-bench
// predictor or a typed expected value. Depends on ffid_pkg and the detector RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 5000;
   localparam int Latency   = 30;

   typedef struct packed {
      logic        fall_event;
      logic        fall_held;
      logic        ready;
      logic [14:0] magnitude;
      logic [14:0] gravity;
   } detect_result_type;

   typedef struct {
      logic signed [11:0] x, y, z;
      logic               typed;
      detect_result_type  res;
   } sample_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   fall_freefall_impact_detector dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor configuration
   logic [1:0]  cfg_shift     = 2'd1;
   logic [7:0]  cfg_low_ratio = 8'd115;
   logic [9:0]  cfg_imp_ratio = 10'd461;
   logic [11:0] cfg_margin    = 12'd614;
   logic [11:0] cfg_floor     = 12'd82;
   logic [15:0] cfg_alpha     = 16'd1966;
   logic [7:0]  cfg_window    = 8'd20;
   logic [7:0]  cfg_cooldown  = 8'd60;

   // predictor state
   logic [19:0] warm_sum   = '0;
   logic [4:0]  warm_count = '0;
   logic [23:0] gravity_q  = '0;
   logic [7:0]  low_run    = '0;
   logic [7:0]  window_left   = '0;
   logic [7:0]  cooldown_left = '0;
   logic [4:0]  hold_left  = '0;
   logic        held       = 1'b0;

   detect_result_type expected_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   logic rx_idle_on = 1'b1;
   logic hold_off_req = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [14:0] floor_root(logic [31:0] v);
      logic [31:0] r;
      logic [31:0] bitv;
      r = 0;
      bitv = 32'h4000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r[14:0];
   endfunction

   function automatic logic [31:0] scaled_abs(logic [11:0] raw);
      logic [31:0] v;
      v = raw[11] ? 32'(4096 - raw) : 32'(raw);
      return v << cfg_shift;
   endfunction

   // update thresholds and baseline; returns 1 on a fall event
   function automatic logic detect_step(logic [14:0] m);
      longint unsigned b, mq, avg, nb;
      b = gravity_q;
      mq = m;
      if (warm_count < ffid_pkg::WarmupSamples) begin
         warm_sum = warm_sum + 20'(m);
         warm_count = warm_count + 1;
         if (warm_count >= ffid_pkg::WarmupSamples) begin
            avg = (longint'(warm_sum) << 8) / ffid_pkg::WarmupSamples;
            if (avg < (longint'(cfg_floor) << 8)) avg = longint'(cfg_floor) << 8;
            gravity_q = avg[23:0];
         end
         return 1'b0;
      end
      if (cooldown_left != 0) begin
         cooldown_left = cooldown_left - 1;
         return 1'b0;
      end
      if ((mq << 16) < b * cfg_low_ratio) begin
         if (low_run != 8'hff) low_run = low_run + 1;
         if (low_run >= ffid_pkg::FreefallMin) window_left = cfg_window;
         return 1'b0;
      end
      if (window_left != 0) begin
         window_left = window_left - 1;
         if ((mq << 16) >= b * cfg_imp_ratio &&
             (mq << 8) >= b + (longint'(cfg_margin) << 8)) begin
            low_run = 0;
            window_left = 0;
            cooldown_left = cfg_cooldown;
            return 1'b1;
         end
      end else begin
         low_run = 0;
         if (mq * 2560 > b * 7 && mq * 2560 < b * 13) begin
            nb = b * (65536 - cfg_alpha) + (mq << 8) * cfg_alpha + 32768;
            gravity_q = nb[39:16];
         end
      end
      return 1'b0;
   endfunction

   function automatic detect_result_type predict_sample(logic [11:0] x, logic [11:0] y,
                                                        logic [11:0] z);
      detect_result_type r;
      logic [31:0] ax, ay, az;
      r = '0;
      ax = scaled_abs(x);
      ay = scaled_abs(y);
      az = scaled_abs(z);
      if (x != 0 || y != 0 || z != 0) begin
         r.magnitude = floor_root(ax * ax + ay * ay + az * az);
         if (hold_left != 0) hold_left = hold_left - 1;
         else held = 1'b0;
         r.fall_event = detect_step(r.magnitude);
         if (r.fall_event) begin
            held = 1'b1;
            hold_left = 5'(ffid_pkg::HoldLength);
         end
      end
      r.fall_held = held;
      r.ready = (warm_count >= ffid_pkg::WarmupSamples);
      r.gravity = gravity_q[22:8];
      return r;
   endfunction

   // register write, mirrored into the predictor
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ffid_pkg::RegCountShift: cfg_shift     = val[1:0];
         ffid_pkg::RegLowGRatio:  cfg_low_ratio = val[7:0];
         ffid_pkg::RegImpRatio:   cfg_imp_ratio = val[9:0];
         ffid_pkg::RegImpMargin:  cfg_margin    = val[11:0];
         ffid_pkg::RegBaseFloor:  cfg_floor     = val[11:0];
         ffid_pkg::RegBaseAlpha:  cfg_alpha     = val;
         ffid_pkg::RegImpWindow:  cfg_window    = val[7:0];
         ffid_pkg::RegCooldown:   cfg_cooldown  = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // send one sample; gaps only while sender idling is on
   task automatic send_sample(logic [11:0] x, logic [11:0] y, logic [11:0] z,
                              logic typed, detect_result_type typed_res, logic gaps);
      detect_result_type p;
      int gap;
      int pick;
      p = predict_sample(x, y, z);
      expected_rsp.push_back(typed ? typed_res : p);
      gap = 0;
      pick = $urandom_range(0, 99);
      if (gaps && pick >= 70) gap = (pick >= 96) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop the request first, then wait for every response
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   // one sample of a given kind around the current 1 g count
   task automatic make_sample(int kind, output logic [11:0] x, output logic [11:0] y,
                              output logic [11:0] z);
      int g1, n, zi;
      g1 = 1024 >> cfg_shift;
      n = g1 / 16 + 1;
      case (kind)
         0: begin  // resting on gravity
            x = 12'($urandom_range(0, 2 * n) - n);
            y = 12'($urandom_range(0, 2 * n) - n);
            z = 12'(g1 + $urandom_range(0, 2 * n) - n);
         end
         1: begin  // free fall
            x = 12'($urandom_range(0, 2 * n) - n);
            y = 12'($urandom_range(0, 2 * n) - n);
            z = 12'($urandom_range(0, 2 * n) - n);
         end
         2: begin  // impact
            zi = g1 * $urandom_range(2, 7);
            if (zi > 2047) zi = 2047;
            x = 12'($urandom_range(0, 4 * n) - 2 * n);
            y = 12'($urandom_range(0, 4 * n) - 2 * n);
            z = $urandom_range(0, 1) ? 12'(zi) : 12'(-zi);
         end
         3: begin
            x = 12'($urandom);
            y = 12'($urandom);
            z = 12'($urandom);
         end
         default: begin
            x = '0;
            y = '0;
            z = '0;
         end
      endcase
   endtask

   // fall-shaped sequences with random content, plus noise
   task automatic random_phase(int items);
      logic [11:0] x, y, z;
      int sent, kind, k, plan[$];
      sent = 0;
      while (sent < items) begin
         plan = {};
         repeat ($urandom_range(2, 12)) plan.push_back(0);
         repeat ($urandom_range(0, 5)) plan.push_back(1);
         repeat ($urandom_range(0, 3)) plan.push_back(0);
         repeat ($urandom_range(0, 2)) plan.push_back(2);
         if ($urandom_range(0, 5) == 0) plan.push_back(3);
         if ($urandom_range(0, 15) == 0) plan.push_back(4);
         for (k = 0; k < plan.size(); k++) begin
            kind = plan[k];
            if ($urandom_range(0, 9) == 0) kind = 3;
            make_sample(kind, x, y, z);
            send_sample(x, y, z, 1'b0, '0, 1'b1);
            sent++;
         end
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   always @(negedge clock) begin : rsp_ready_gen
      static int stall = 0;
      static int pick = 0;
      static logic hold_done = 1'b0;
      logic rdy;
      if (reset) begin
         rdy = 1'b0;
      end else if (hold_off_req && !hold_done) begin
         stall = 400;
         hold_done = 1'b1;
         rdy = 1'b0;
      end else if (stall > 0) begin
         stall--;
         rdy = 1'b0;
      end else begin
         rdy = 1'b1;
         pick = $urandom_range(0, 99);
         if (rx_idle_on && pick < 25) stall = $urandom_range(1, 3);
         else if (rx_idle_on && pick < 28) stall = $urandom_range(20, 80);
      end
      rsp_tready <= rdy;
   end

   // compare responses
   always @(posedge clock) begin : rsp_check
      detect_result_type e;
      logic [14:0] got_mag;
      logic [14:0] got_grav;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_mag = rsp_tdata[17:3];
         got_grav = rsp_tdata[32:18];
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transaction %h", rsp_tdata);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_tdata[0] !== e.fall_event || rsp_tdata[1] !== e.fall_held ||
                rsp_tdata[2] !== e.ready || got_mag !== e.magnitude ||
                got_grav !== e.gravity) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp ev=%0d held=%0d rdy=%0d mag=%0d grav=%0d %s",
                           e.fall_event, e.fall_held, e.ready, e.magnitude,
                           e.gravity, $sformatf("got ev=%0d held=%0d rdy=%0d mag=%0d grav=%0d",
                           rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], got_mag, got_grav));
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // directed samples: typed rows are before warmup ends, default scale
   sample_row_type directed[$] = '{
      '{12'sd0,     12'sd0,     12'sd0,     1'b1, '{1'b0, 1'b0, 1'b0, 15'd0,    15'd0}},
      '{12'sd512,   12'sd0,     12'sd0,     1'b1, '{1'b0, 1'b0, 1'b0, 15'd1024, 15'd0}},
      '{12'sh800,   12'sh800,   12'sh800,   1'b1, '{1'b0, 1'b0, 1'b0, 15'd7094, 15'd0}},
      '{12'sd2047,  12'sd2047,  12'sd2047,  1'b0, '0},
      '{12'sd0,     -12'sd1,    12'sd1,     1'b0, '0},
      '{12'sd0,     12'sd0,     12'sd512,   1'b0, '0},
      '{12'sd0,     12'sd512,   12'sd0,     1'b0, '0}
   };

   initial begin
      logic [11:0] x, y, z;
      int i, p;
      // count_shift, low ratio, impact ratio, margin, floor, alpha, window, cooldown
      static logic [15:0] settings[8][8] = '{
         '{16'd1, 16'd115, 16'd461,  16'd614,  16'd82,   16'd1966,  16'd20,  16'd60},
         '{16'd0, 16'd255, 16'd1023, 16'd4095, 16'd0,    16'd65535, 16'd255, 16'd255},
         '{16'd3, 16'd0,   16'd0,    16'd0,    16'd4095, 16'd0,     16'd1,   16'd0},
         '{16'd2, 16'd128, 16'd300,  16'd200,  16'd100,  16'd8000,  16'd5,   16'd3},
         '{16'd1, 16'd200, 16'd256,  16'd100,  16'd82,   16'd30000, 16'd10,  16'd0},
         '{16'd3, 16'd150, 16'd400,  16'd50,   16'd82,   16'd1,     16'd30,  16'd10},
         '{16'd0, 16'd100, 16'd500,  16'd300,  16'd82,   16'd4000,  16'd2,   16'd1},
         '{16'd1, 16'd115, 16'd461,  16'd614,  16'd82,   16'd1966,  16'd20,  16'd60}};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // walk the directed table, then finish warmup on gravity samples
      foreach (directed[row])
         send_sample(directed[row].x, directed[row].y, directed[row].z,
                     directed[row].typed, directed[row].res, 1'b0);
      repeat (16) begin
         make_sample(0, x, y, z);
         send_sample(x, y, z, 1'b0, '0, 1'b1);
      end
      random_phase(60);
      wait_drained();
      // sweep register settings; idle between phases
      for (p = 0; p < 8; p++) begin
         for (i = 0; i < 8; i++) write_reg(3'(i), settings[p][i]);
         rx_idle_on = (p != 3);
         hold_off_req = (p == 4);
         random_phase(80);
         wait_drained();
      end
      for (p = 0; p < 2; p++) begin
         write_reg(ffid_pkg::RegCountShift, 16'($urandom_range(0, 3)));
         write_reg(ffid_pkg::RegLowGRatio, 16'($urandom_range(80, 200)));
         write_reg(ffid_pkg::RegImpRatio, 16'($urandom_range(256, 600)));
         write_reg(ffid_pkg::RegImpMargin, 16'($urandom_range(0, 700)));
         write_reg(ffid_pkg::RegBaseAlpha, 16'($urandom));
         write_reg(ffid_pkg::RegImpWindow, 16'($urandom_range(1, 255)));
         write_reg(ffid_pkg::RegCooldown, 16'($urandom_range(0, 255)));
         random_phase(40);
         wait_drained();
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
